FILE: rtl/core/tbcs_pkg.sv
package tbcs_pkg;

  // default sizing of the point store and the coordinate format
  localparam int unsigned MAX_POINTS_DEF = 1024;
  localparam int unsigned COORD_BITS_DEF = 16;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_COUNT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CANDS_PER_ROUND = 2'd1;

  localparam int unsigned TARGET_W = 11;
  localparam int unsigned ROUND_W = 8;
  localparam logic [ROUND_W-1:0] ROUND_RESET = 8'd64;

  // payload fields
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned INDEX_W = 10;

  typedef struct packed {
    logic [FIELD_W-1:0] cand_x;
    logic [FIELD_W-1:0] cand_y;
  } cand_t;

  typedef struct packed {
    logic [FIELD_W-1:0] point_x;
    logic [FIELD_W-1:0] point_y;
    logic [INDEX_W-1:0] point_index;
    logic               last_point;
  } point_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } state_t;

endpackage

FILE: rtl/core/toroidal_best_candidate_sampler.sv
// Best-candidate point sampler on the unit torus.
// Input channel (in_valid/in_ready/in_data) carries candidate points in
// Q0.16; output channel (out_valid/out_ready/out_data) carries one accepted
// point at the end of every round of candidates_per_round candidates.
// Config port: cfg_we/cfg_addr/cfg_wdata, index 0 target_count, index 1
// candidates_per_round (0 means 256); write only while the block is idle.
// Each candidate is compared against every stored point through one shared
// distance pipeline fed by a single read port of the point store, one
// stored point per cycle. in_ready stays low from a candidate's transfer
// until its scan and decision are done and, when it closes a round, until
// the round's point is stored, so a new candidate is taken only after the
// last is through. The closing candidate is scanned and decided on, then
// its round's point is stored and loaded into the output register.
// Candidates that arrive once target_count points exist are taken as soon
// as they are presented and give no result.
// The output register holds a finished point until it is taken; a round end
// that meets a full output register waits for out_ready before storing.
// Reset (rst_n, synchronous) clears counters, round state and the output
// valid; the store needs no clearing pass since only written entries are read.
module toroidal_best_candidate_sampler #(
  parameter int unsigned MAX_POINTS = tbcs_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_BITS = tbcs_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  tbcs_pkg::cand_t                 in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output tbcs_pkg::point_t                out_data,
  input  logic                            cfg_we,
  input  logic [tbcs_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tbcs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned SW    = 2 * CB;
  localparam int unsigned DW    = 2 * CB + 1;
  localparam int unsigned AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned TW    = (CNT_W > tbcs_pkg::TARGET_W) ? CNT_W : tbcs_pkg::TARGET_W;
  localparam int unsigned RW    = tbcs_pkg::ROUND_W;

  localparam logic [DW-1:0] DIST_INF = DW'(1) << SW;
  localparam logic [TW-1:0] TARGET_MAX = TW'(MAX_POINTS);

  // configuration registers
  logic [tbcs_pkg::TARGET_W-1:0] target_r;
  logic [RW-1:0]                 round_r;

  // sequencer and round state
  tbcs_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] accepted_r;
  logic [RW-1:0]    seen_r;
  logic [DW-1:0]    best_dist_r;
  logic [SW-1:0]    best_pt_r;
  logic [CB-1:0]    cand_x_r, cand_y_r;

  // scan pipeline
  logic [CNT_W-1:0] iss_cnt_r;
  logic             s1_v_r, s2_v_r, s3_v_r;
  logic [SW-1:0]    rd_data_r;
  logic [CB-1:0]    dx_r, dy_r;
  logic [SW-1:0]    sqx_r, sqy_r;
  logic [DW-1:0]    min_r;

  // output register
  logic             out_valid_r;
  tbcs_pkg::point_t out_data_r;

  // point store
  logic [SW-1:0] mem [MAX_POINTS];

  // control
  logic          rd_en, out_load, scan_done, active, round_end;
  logic [TW-1:0] target_eff;
  logic [RW:0]   round_len, seen_inc;
  logic [CB-1:0] in_x, in_y;
  logic [CB-1:0] ax_c, ay_c;
  logic [SW-1:0] sqx_c, sqy_c;
  logic [DW-1:0] sum_c;
  logic [TW-1:0] accepted_inc;

  // wrapped per-axis distance: min(|a-b|, 2^CB - |a-b|)
  function automatic logic [CB-1:0] axis_dist(input logic [CB-1:0] a, input logic [CB-1:0] b);
    logic [CB-1:0] d;
    logic [CB:0]   w;
    d = (a >= b) ? (a - b) : (b - a);
    w = (CB+1)'(1) << CB;
    w = w - {1'b0, d};
    axis_dist = (w < {1'b0, d}) ? w[CB-1:0] : d;
  endfunction

  assign in_x = CB'(in_data.cand_x);
  assign in_y = CB'(in_data.cand_y);

  assign target_eff = (TW'(target_r) > TARGET_MAX) ? TARGET_MAX : TW'(target_r);
  assign active     = TW'(accepted_r) < target_eff;
  assign round_len  = (round_r == '0) ? (RW+1)'(1 << RW) : {1'b0, round_r};
  assign seen_inc   = {1'b0, seen_r} + 1'b1;
  assign round_end  = seen_inc >= round_len;
  assign scan_done  = (iss_cnt_r == accepted_r) && !s1_v_r && !s2_v_r && !s3_v_r;
  assign accepted_inc = TW'(accepted_r) + 1'b1;

  // distance datapath
  assign ax_c  = axis_dist(rd_data_r[CB-1:0], cand_x_r);
  assign ay_c  = axis_dist(rd_data_r[SW-1:CB], cand_y_r);
  assign sqx_c = dx_r * dx_r;
  assign sqy_c = dy_r * dy_r;
  assign sum_c = DW'(sqx_r) + DW'(sqy_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tbcs_pkg::ST_IDLE: begin
        if (in_valid && active) state_nxt = tbcs_pkg::ST_SCAN;
      end
      tbcs_pkg::ST_SCAN: begin
        if (scan_done) state_nxt = tbcs_pkg::ST_DECIDE;
      end
      tbcs_pkg::ST_DECIDE: begin
        state_nxt = round_end ? tbcs_pkg::ST_EMIT : tbcs_pkg::ST_IDLE;
      end
      tbcs_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ready) state_nxt = tbcs_pkg::ST_IDLE;
      end
      default: state_nxt = tbcs_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      tbcs_pkg::ST_IDLE:   in_ready = 1'b1;
      tbcs_pkg::ST_SCAN:   rd_en = iss_cnt_r < accepted_r;
      tbcs_pkg::ST_DECIDE: ;
      tbcs_pkg::ST_EMIT:   out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      round_r  <= tbcs_pkg::ROUND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tbcs_pkg::CFG_TARGET_COUNT:    target_r <= cfg_wdata;
        tbcs_pkg::CFG_CANDS_PER_ROUND: round_r  <= cfg_wdata[RW-1:0];
        default: ;
      endcase
    end
  end

  // point store: one read port for the scan, one write at round end
  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[iss_cnt_r[AW-1:0]];
    if (out_load) mem[accepted_r[AW-1:0]] <= best_pt_r;
  end

  // distance pipeline payload
  always_ff @(posedge clk) begin
    dx_r  <= ax_c;
    dy_r  <= ay_c;
    sqx_r <= sqx_c;
    sqy_r <= sqy_c;
    if (in_valid && in_ready) begin
      cand_x_r <= in_x;
      cand_y_r <= in_y;
    end
  end

  // sequencer, round state and scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tbcs_pkg::ST_IDLE;
      accepted_r  <= '0;
      seen_r      <= '0;
      best_dist_r <= '0;
      best_pt_r   <= '0;
      iss_cnt_r   <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      min_r       <= DIST_INF;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= rd_en;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      // start of a scan
      if (in_valid && in_ready && active) begin
        iss_cnt_r <= '0;
        min_r     <= DIST_INF;
      end else begin
        if (rd_en) iss_cnt_r <= iss_cnt_r + 1'b1;
        if (s3_v_r && (sum_c < min_r)) min_r <= sum_c;
      end
      // keep the first strictly farther candidate of the round
      if (state_r == tbcs_pkg::ST_DECIDE) begin
        if (min_r > best_dist_r) begin
          best_dist_r <= min_r;
          best_pt_r   <= {cand_y_r, cand_x_r};
        end
        if (!round_end) seen_r <= seen_inc[RW-1:0];
      end
      // store the round's point and clear the round
      if (out_load) begin
        accepted_r  <= accepted_r + 1'b1;
        seen_r      <= '0;
        best_dist_r <= '0;
        best_pt_r   <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.point_x     <= tbcs_pkg::FIELD_W'(best_pt_r[CB-1:0]);
      out_data_r.point_y     <= tbcs_pkg::FIELD_W'(best_pt_r[SW-1:CB]);
      out_data_r.point_index <= tbcs_pkg::INDEX_W'(accepted_r);
      out_data_r.last_point  <= accepted_inc == target_eff;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    accepted_r <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store depth");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    iss_cnt_r <= accepted_r)
    else $error("scan read past stored points");

  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tbcs_pkg::ST_DECIDE) |-> (!s1_v_r && !s2_v_r && !s3_v_r))
    else $error("decision taken with distances in flight");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (accepted_r == $past(accepted_r) + 1'b1) && out_valid_r)
    else $error("stored point not counted or not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !out_load)
    else $error("output register overwritten while stalled");

endmodule
